@@ rtl/e820c_pkg.sv @@
// Shared types, constants and the type mapping function of the E820 coalescer.
`timescale 1ns / 1ps
package e820c_pkg;

	localparam int unsigned PAGE_SHIFT      = 12;
	localparam int unsigned MAX_ENTRIES_DEF = 32;
	localparam int unsigned CNT_W           = 6;
	localparam int unsigned RQ_DEPTH        = 4;
	localparam int unsigned RQ_PTR_W        = $clog2(RQ_DEPTH);

	localparam logic [1:0] STATUS_ENTRY    = 2'd0;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
	localparam logic [1:0] STATUS_EMPTY    = 2'd2;

	localparam logic [2:0] LEGACY_NONE      = 3'd0;
	localparam logic [2:0] LEGACY_AVAILABLE = 3'd1;
	localparam logic [2:0] LEGACY_RESERVED  = 3'd2;
	localparam logic [2:0] LEGACY_ACPI      = 3'd3;
	localparam logic [2:0] LEGACY_NVS       = 3'd4;
	localparam logic [2:0] LEGACY_UNUSABLE  = 3'd5;

	localparam logic [31:0] FW_LOADER_CODE   = 32'd1;
	localparam logic [31:0] FW_LOADER_DATA   = 32'd2;
	localparam logic [31:0] FW_BOOT_CODE     = 32'd3;
	localparam logic [31:0] FW_BOOT_DATA     = 32'd4;
	localparam logic [31:0] FW_CONVENTIONAL  = 32'd7;
	localparam logic [31:0] FW_UNUSABLE      = 32'd8;
	localparam logic [31:0] FW_ACPI_RECLAIM  = 32'd9;
	localparam logic [31:0] FW_ACPI_NVS      = 32'd10;

	typedef struct packed {
		logic [63:0] base;
		logic [63:0] size;
		logic [2:0]  etype;
		logic [1:0]  status;
		logic        eom;
	} result_t;

	function automatic logic [2:0] legacy_type(input logic [31:0] fw_type);
		logic [2:0] t;
		unique case (fw_type)
			FW_LOADER_CODE, FW_LOADER_DATA, FW_BOOT_CODE, FW_BOOT_DATA,
			FW_CONVENTIONAL: t = LEGACY_AVAILABLE;
			FW_ACPI_RECLAIM: t = LEGACY_ACPI;
			FW_ACPI_NVS:     t = LEGACY_NVS;
			FW_UNUSABLE:     t = LEGACY_UNUSABLE;
			default:         t = LEGACY_RESERVED;
		endcase
		return t;
	endfunction

endpackage

@@ rtl/e820c_rq.sv @@
// Result queue that takes up to two results per cycle and gives one per cycle while out_ready is high.
`timescale 1ns / 1ps
module e820c_rq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push0,
	input  logic               push1,
	input  e820c_pkg::result_t d0,
	input  e820c_pkg::result_t d1,
	output logic               room2,
	output logic               out_valid,
	input  logic               out_ready,
	output e820c_pkg::result_t dout
);
	import e820c_pkg::*;

	result_t               mem_q [RQ_DEPTH];
	logic [RQ_PTR_W-1:0]   wr_ptr_q;
	logic [RQ_PTR_W-1:0]   rd_ptr_q;
	logic [RQ_PTR_W:0]     count_q;
	logic                  pop;
	logic [RQ_PTR_W:0]     n_push;

	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign dout      = mem_q[rd_ptr_q];
	assign room2     = (count_q <= (RQ_PTR_W+1)'(RQ_DEPTH - 2));
	assign n_push    = (RQ_PTR_W+1)'(push0) + (RQ_PTR_W+1)'(push1);

	always_ff @(posedge clk) begin
		if (push0) begin
			mem_q[wr_ptr_q] <= d0;
		end
		if (push1) begin
			mem_q[wr_ptr_q + RQ_PTR_W'(1)] <= d1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push[RQ_PTR_W-1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + RQ_PTR_W'(1);
			end
			count_q <= count_q + n_push - (RQ_PTR_W+1)'(pop);
		end
	end

endmodule

@@ rtl/e820c_core.sv @@
// Input register, held entry state and the merge, emit and overflow decision.
`timescale 1ns / 1ps
module e820c_core #(
	parameter int unsigned MAX_ENTRIES = e820c_pkg::MAX_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [63:0]                 phys_base,
	input  logic [51:0]                 page_count,
	input  logic [31:0]                 descriptor_type,
	input  logic                        is_last,
	input  logic                        cfg_wr_en,
	input  logic [e820c_pkg::CNT_W-1:0] cfg_wr_data,
	input  logic                        room2,
	output logic                        push0,
	output logic                        push1,
	output e820c_pkg::result_t          r0,
	output e820c_pkg::result_t          r1
);
	import e820c_pkg::*;

	logic              valid_s1;
	logic [63:0]       base_s1;
	logic [51:0]       pages_s1;
	logic [31:0]       ftype_s1;
	logic              last_s1;

	logic [CNT_W-1:0]  max_entries_q;
	logic [63:0]       held_base_q;
	logic [63:0]       held_size_q;
	logic [63:0]       held_end_q;
	logic [2:0]        held_type_q;
	logic              held_valid_q;
	logic [CNT_W-1:0]  entry_count_q;
	logic              overflowed_q;

	logic              advance;
	logic [63:0]       size;
	logic              nonzero;
	logic [2:0]        ltype;
	logic              merge;
	logic              fresh;
	logic              ovf;
	logic              emit_held;
	logic [63:0]       nbase;
	logic [63:0]       nsize;
	logic [63:0]       nend;
	logic [2:0]        ntype;
	logic              nvalid;
	result_t           held_res;
	result_t           final_res;

	assign advance  = valid_s1 && room2;
	assign in_ready = !valid_s1 || room2;

	assign size    = {pages_s1, PAGE_SHIFT'(0)};
	assign nonzero = |pages_s1;
	assign ltype   = legacy_type(ftype_s1);
	assign merge   = held_valid_q && (held_type_q == ltype) && (held_end_q == base_s1);
	assign fresh   = nonzero && !merge;
	assign ovf     = !overflowed_q && fresh && (entry_count_q >= max_entries_q);
	assign emit_held = !overflowed_q && !ovf && fresh && held_valid_q;

	always_comb begin
		nbase  = held_base_q;
		nsize  = held_size_q;
		nend   = held_end_q;
		ntype  = held_type_q;
		nvalid = held_valid_q;
		if (nonzero && merge) begin
			nsize = held_size_q + size;
			nend  = held_end_q + size;
		end else if (fresh) begin
			nbase  = base_s1;
			nsize  = size;
			nend   = base_s1 + size;
			ntype  = ltype;
			nvalid = 1'b1;
		end
	end

	always_comb begin
		held_res = '{base: held_base_q, size: held_size_q, etype: held_type_q,
			status: STATUS_ENTRY, eom: 1'b0};
		if (nvalid) begin
			final_res = '{base: nbase, size: nsize, etype: ntype,
				status: STATUS_ENTRY, eom: 1'b1};
		end else begin
			final_res = '{base: 64'd0, size: 64'd0, etype: LEGACY_NONE,
				status: STATUS_EMPTY, eom: 1'b1};
		end
	end

	always_comb begin
		push0 = 1'b0;
		push1 = 1'b0;
		r0    = held_res;
		r1    = final_res;
		if (advance && !overflowed_q) begin
			if (ovf) begin
				push0 = 1'b1;
				r0 = '{base: 64'd0, size: 64'd0, etype: LEGACY_NONE,
					status: STATUS_OVERFLOW, eom: 1'b1};
			end else if (emit_held) begin
				push0 = 1'b1;
				push1 = last_s1;
			end else if (last_s1) begin
				push0 = 1'b1;
				r0 = final_res;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			base_s1  <= phys_base;
			pages_s1 <= page_count;
			ftype_s1 <= descriptor_type;
			last_s1  <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= CNT_W'(MAX_ENTRIES);
		end else if (cfg_wr_en) begin
			max_entries_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_base_q   <= '0;
			held_size_q   <= '0;
			held_end_q    <= '0;
			held_type_q   <= '0;
			held_valid_q  <= 1'b0;
			entry_count_q <= '0;
			overflowed_q  <= 1'b0;
		end else if (advance) begin
			if (last_s1 || ovf) begin
				held_base_q   <= '0;
				held_size_q   <= '0;
				held_end_q    <= '0;
				held_type_q   <= '0;
				held_valid_q  <= 1'b0;
				entry_count_q <= '0;
				overflowed_q  <= ovf && !last_s1;
			end else if (!overflowed_q) begin
				held_base_q  <= nbase;
				held_size_q  <= nsize;
				held_end_q   <= nend;
				held_type_q  <= ntype;
				held_valid_q <= nvalid;
				if (fresh) begin
					entry_count_q <= entry_count_q + CNT_W'(1);
				end
			end
		end
	end

endmodule

@@ rtl/memory_map_to_e820_coalescer_unit.sv @@
// Top level of the firmware memory map to E820 map coalescer.
`timescale 1ns / 1ps
// One firmware descriptor beat is taken per cycle; it is registered, decided
// against the held entry once the queue has room, and its zero, one or two
// results go into a four-deep result queue that drives the output port. The
// block sustains one descriptor per cycle as long as the queue has room for
// two results, which holds whenever results are taken about as fast as they
// are made. The max_entries register may be rewritten only while the block is
// idle.
module memory_map_to_e820_coalescer_unit #(
	parameter int unsigned MAX_ENTRIES = e820c_pkg::MAX_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [e820c_pkg::CNT_W-1:0] cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [63:0]                 phys_base,
	input  logic [51:0]                 page_count,
	input  logic [31:0]                 descriptor_type,
	input  logic                        is_last,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [63:0]                 entry_base,
	output logic [63:0]                 entry_size,
	output logic [2:0]                  entry_type,
	output logic [1:0]                  status,
	output logic                        end_of_map
);
	import e820c_pkg::*;

	logic    room2;
	logic    push0;
	logic    push1;
	result_t r0;
	result_t r1;
	result_t dout;

	e820c_core #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.phys_base      (phys_base),
		.page_count     (page_count),
		.descriptor_type(descriptor_type),
		.is_last        (is_last),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.room2          (room2),
		.push0          (push0),
		.push1          (push1),
		.r0             (r0),
		.r1             (r1)
	);

	e820c_rq u_rq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push0    (push0),
		.push1    (push1),
		.d0       (r0),
		.d1       (r1),
		.room2    (room2),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.dout     (dout)
	);

	assign entry_base = dout.base;
	assign entry_size = dout.size;
	assign entry_type = dout.etype;
	assign status     = dout.status;
	assign end_of_map = dout.eom;

endmodule

@@ tb/tb_memory_map_to_e820_coalescer_unit.sv @@
// Self-checking testbench for the E820 coalescer: directed rows, then random maps.
`timescale 1ns / 1ps
module tb_memory_map_to_e820_coalescer_unit;
	import e820c_pkg::*;

	localparam int SETTLE_CYCLES = 10;
	localparam int PHASE_ITEMS   = 144;
	localparam int PHASE_COUNT   = 8;

	localparam logic [31:0] FW_RESERVED_MEM = 32'd0;
	localparam logic [31:0] FW_RUNTIME_CODE = 32'd5;
	localparam logic [31:0] FW_RUNTIME_DATA = 32'd6;
	localparam logic [31:0] FW_MMIO         = 32'd11;
	localparam logic [31:0] FW_MMIO_PORT    = 32'd12;
	localparam logic [31:0] FW_PAL_CODE     = 32'd13;
	localparam logic [31:0] FW_PERSISTENT   = 32'd14;

	typedef struct packed {
		logic [63:0] base;
		logic [51:0] pages;
		logic [31:0] dtype;
		logic        last;
	} desc_t;

	typedef enum logic {ROW_DESC, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		desc_t       desc;
		bit          typed;
		result_t     want;
		logic [5:0]  limit;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en;
	logic [CNT_W-1:0] cfg_wr_data;
	logic in_valid;
	logic in_ready;
	logic [63:0] phys_base;
	logic [51:0] page_count;
	logic [31:0] descriptor_type;
	logic is_last;
	logic out_valid;
	logic out_ready;
	logic [63:0] entry_base;
	logic [63:0] entry_size;
	logic [2:0] entry_type;
	logic [1:0] status;
	logic end_of_map;

	memory_map_to_e820_coalescer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.phys_base(phys_base),
		.page_count(page_count),
		.descriptor_type(descriptor_type),
		.is_last(is_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.entry_base(entry_base),
		.entry_size(entry_size),
		.entry_type(entry_type),
		.status(status),
		.end_of_map(end_of_map)
	);

	always #5 clk = ~clk;

	result_t awaited_entries[$];
	stim_row_t directed_rows[$];
	int mismatch_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	logic [5:0]  limit_model;
	logic [63:0] acc_base;
	logic [63:0] acc_size;
	logic [2:0]  acc_type;
	logic        acc_valid;
	logic [5:0]  acc_count;
	logic        map_dropped;

	int          map_left = 0;
	logic [63:0] next_addr = '0;
	logic [31:0] last_fw_type = FW_CONVENTIONAL;

	function automatic result_t make_entry(input logic [63:0] b, input logic [63:0] s,
			input logic [2:0] t, input logic [1:0] st, input logic eom);
		result_t r;
		r.base = b;
		r.size = s;
		r.etype = t;
		r.status = st;
		r.eom = eom;
		return r;
	endfunction

	function automatic logic [2:0] to_e820_type(input logic [31:0] code);
		if (code == FW_LOADER_CODE || code == FW_LOADER_DATA || code == FW_BOOT_CODE ||
				code == FW_BOOT_DATA || code == FW_CONVENTIONAL)
			return LEGACY_AVAILABLE;
		if (code == FW_ACPI_RECLAIM)
			return LEGACY_ACPI;
		if (code == FW_ACPI_NVS)
			return LEGACY_NVS;
		if (code == FW_UNUSABLE)
			return LEGACY_UNUSABLE;
		return LEGACY_RESERVED;
	endfunction

	function automatic void clear_map_model();
		acc_base = '0;
		acc_size = '0;
		acc_type = LEGACY_NONE;
		acc_valid = 1'b0;
		acc_count = '0;
		map_dropped = 1'b0;
	endfunction

	function automatic void fold_descriptor(input desc_t d);
		logic [63:0] bytes;
		logic [2:0] kind;
		bytes = {d.pages, 12'h000};
		kind = to_e820_type(d.dtype);
		if (map_dropped) begin
			if (d.last)
				clear_map_model();
			return;
		end
		if (bytes != '0) begin
			if (acc_valid && acc_type == kind && acc_base + acc_size == d.base) begin
				acc_size = acc_size + bytes;
			end else if (acc_count >= limit_model) begin
				awaited_entries.push_back(make_entry('0, '0, LEGACY_NONE, STATUS_OVERFLOW,
					1'b1));
				clear_map_model();
				if (!d.last)
					map_dropped = 1'b1;
				return;
			end else begin
				if (acc_valid)
					awaited_entries.push_back(make_entry(acc_base, acc_size, acc_type,
						STATUS_ENTRY, 1'b0));
				acc_base = d.base;
				acc_size = bytes;
				acc_type = kind;
				acc_valid = 1'b1;
				acc_count = acc_count + 6'd1;
			end
		end
		if (d.last) begin
			if (acc_valid)
				awaited_entries.push_back(make_entry(acc_base, acc_size, acc_type,
					STATUS_ENTRY, 1'b1));
			else
				awaited_entries.push_back(make_entry('0, '0, LEGACY_NONE, STATUS_EMPTY, 1'b1));
			clear_map_model();
		end
	endfunction

	function automatic desc_t make_desc(input logic [63:0] b, input logic [51:0] p,
			input logic [31:0] t, input logic l);
		desc_t d;
		d.base = b;
		d.pages = p;
		d.dtype = t;
		d.last = l;
		return d;
	endfunction

	function automatic void add_desc(input logic [63:0] b, input logic [51:0] p,
			input logic [31:0] t, input logic l);
		stim_row_t r;
		r.kind = ROW_DESC;
		r.desc = make_desc(b, p, t, l);
		r.typed = 1'b0;
		r.want = '0;
		r.limit = '0;
		directed_rows.push_back(r);
	endfunction

	function automatic void add_flagged(input logic [63:0] b, input logic [51:0] p,
			input logic [31:0] t, input logic l, input logic [1:0] st);
		stim_row_t r;
		r.kind = ROW_DESC;
		r.desc = make_desc(b, p, t, l);
		r.typed = 1'b1;
		r.want = make_entry('0, '0, LEGACY_NONE, st, 1'b1);
		r.limit = '0;
		directed_rows.push_back(r);
	endfunction

	function automatic void add_cfg(input logic [5:0] v);
		stim_row_t r;
		r.kind = ROW_CFG;
		r.desc = '0;
		r.typed = 1'b0;
		r.want = '0;
		r.limit = v;
		directed_rows.push_back(r);
	endfunction

	function automatic logic [31:0] fw_type_code(input int i);
		case (i)
			0: return FW_RESERVED_MEM;
			1: return FW_LOADER_CODE;
			2: return FW_LOADER_DATA;
			3: return FW_BOOT_CODE;
			4: return FW_BOOT_DATA;
			5: return FW_RUNTIME_CODE;
			6: return FW_RUNTIME_DATA;
			7: return FW_CONVENTIONAL;
			8: return FW_UNUSABLE;
			9: return FW_ACPI_RECLAIM;
			10: return FW_ACPI_NVS;
			11: return FW_MMIO;
			12: return FW_MMIO_PORT;
			13: return FW_PAL_CODE;
			default: return FW_PERSISTENT;
		endcase
	endfunction

	function automatic desc_t random_descriptor();
		desc_t d;
		int pick;
		logic [63:0] wide;
		if (map_left == 0) begin
			map_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 45);
			wide = {$urandom, $urandom};
			next_addr = ($urandom_range(0, 9) == 0) ? wide : {28'h0, wide[35:12], 12'h000};
		end
		pick = $urandom_range(0, 99);
		wide = {$urandom, $urandom};
		if (pick < 75)
			d.base = next_addr;
		else if (pick < 85)
			d.base = next_addr + ({32'h0, $urandom_range(1, 4)} << 12);
		else if (pick < 95)
			d.base = {wide[63:12], 12'h000};
		else
			d.base = wide;
		pick = $urandom_range(0, 99);
		wide = {$urandom, $urandom};
		if (pick < 75)
			d.pages = 52'($urandom_range(1, 16));
		else if (pick < 83)
			d.pages = '0;
		else if (pick < 95)
			d.pages = wide[51:0];
		else
			d.pages = '1;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			d.dtype = last_fw_type;
		else if (pick < 95)
			d.dtype = fw_type_code($urandom_range(0, 14));
		else
			d.dtype = $urandom;
		last_fw_type = d.dtype;
		map_left = map_left - 1;
		d.last = (map_left == 0) || ($urandom_range(0, 99) < 3);
		if (d.last)
			map_left = 0;
		next_addr = d.base + {d.pages, 12'h000};
		return d;
	endfunction

	function automatic logic [5:0] phase_limit(input int ph);
		case (ph)
			0: return 6'd1;
			1: return 6'd63;
			2: return 6'd32;
			3: return 6'd3;
			7: return 6'd32;
			default: return 6'($urandom_range(1, 63));
		endcase
	endfunction

	task automatic note_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic take_result();
		result_t want;
		if (awaited_entries.size() == 0) begin
			note_mismatch($sformatf("unexpected beat base=%h size=%h type=%0d status=%0d eom=%0d",
				entry_base, entry_size, entry_type, status, end_of_map));
			return;
		end
		want = awaited_entries.pop_front();
		if (entry_base !== want.base)
			note_mismatch($sformatf("entry_base %h, want %h", entry_base, want.base));
		if (entry_size !== want.size)
			note_mismatch($sformatf("entry_size %h, want %h", entry_size, want.size));
		if (entry_type !== want.etype)
			note_mismatch($sformatf("entry_type %0d, want %0d", entry_type, want.etype));
		if (status !== want.status)
			note_mismatch($sformatf("status %0d, want %0d", status, want.status));
		if (end_of_map !== want.eom)
			note_mismatch($sformatf("end_of_map %0d, want %0d", end_of_map, want.eom));
	endtask

	task automatic transmit_descriptor(input desc_t d, input bit typed, input result_t want);
		int before_size;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		phys_base <= d.base;
		page_count <= d.pages;
		descriptor_type <= d.dtype;
		is_last <= d.last;
		do @(posedge clk); while (in_ready !== 1'b1);
		before_size = awaited_entries.size();
		fold_descriptor(d);
		if (typed) begin
			while (awaited_entries.size() > before_size)
				void'(awaited_entries.pop_back());
			awaited_entries.push_back(want);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (awaited_entries.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_max_entries(input logic [5:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		limit_model = v;
	endtask

	initial begin
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready === 1'b1)
				take_result();
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	initial begin
		#5ms;
		$display("[memory_map_to_e820_coalescer_unit] ERROR");
		$finish;
	end

	initial begin
		result_t none;
		desc_t d;
		none = '0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		in_valid <= 1'b0;
		phys_base <= '0;
		page_count <= '0;
		descriptor_type <= '0;
		is_last <= 1'b0;
		limit_model = CNT_W'(MAX_ENTRIES_DEF);
		clear_map_model();

		add_flagged(64'h0, 52'h0, FW_CONVENTIONAL, 1'b1, STATUS_EMPTY);
		add_desc(64'h1000, 52'd1, FW_CONVENTIONAL, 1'b0);
		add_desc(64'h2000, 52'd2, FW_LOADER_CODE, 1'b0);
		add_desc(64'h4000, 52'd0, FW_ACPI_RECLAIM, 1'b0);
		add_desc(64'h4000, 52'd1, FW_ACPI_RECLAIM, 1'b0);
		add_desc(64'h5000, 52'd3, FW_ACPI_NVS, 1'b0);
		add_desc(64'h8000, 52'd1, FW_UNUSABLE, 1'b0);
		add_desc(64'h9000, 52'd1, FW_RESERVED_MEM, 1'b0);
		add_desc(64'hA000, 52'd1, 32'hFFFF_FFFF, 1'b0);
		add_desc(64'hB000, 52'd1, FW_LOADER_DATA, 1'b0);
		add_desc(64'hC000, 52'd1, FW_BOOT_CODE, 1'b0);
		add_desc(64'hD000, 52'd1, FW_BOOT_DATA, 1'b1);
		add_desc(64'h0, 52'hF_FFFF_FFFF_FFFF, FW_CONVENTIONAL, 1'b0);
		add_desc(64'hFFFF_FFFF_FFFF_F000, 52'd1, FW_CONVENTIONAL, 1'b0);
		add_desc(64'hFFFF_FFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF, FW_RUNTIME_DATA, 1'b1);
		add_cfg(6'd1);
		add_desc(64'h1000, 52'd1, FW_CONVENTIONAL, 1'b0);
		add_flagged(64'h3000, 52'd1, FW_UNUSABLE, 1'b0, STATUS_OVERFLOW);
		add_desc(64'h4000, 52'd1, FW_UNUSABLE, 1'b0);
		add_desc(64'h5000, 52'd0, FW_RESERVED_MEM, 1'b1);
		add_desc(64'h1000, 52'd1, FW_CONVENTIONAL, 1'b0);
		add_flagged(64'h9000, 52'd1, FW_ACPI_NVS, 1'b1, STATUS_OVERFLOW);
		add_cfg(6'd0);
		add_flagged(64'h1000, 52'd1, FW_CONVENTIONAL, 1'b1, STATUS_OVERFLOW);
		add_flagged(64'h0, 52'd0, FW_RESERVED_MEM, 1'b1, STATUS_EMPTY);
		add_cfg(6'd63);
		add_desc(64'h1000, 52'd2, FW_ACPI_NVS, 1'b0);
		add_desc(64'h3000, 52'd1, FW_ACPI_NVS, 1'b1);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				drain_results();
				write_max_entries(directed_rows[i].limit);
			end else begin
				transmit_descriptor(directed_rows[i].desc, directed_rows[i].typed,
					directed_rows[i].want);
			end
		end

		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			drain_results();
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 54; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 54; end
				default: begin send_idle_pct = 22; recv_stall_pct = 22; end
			endcase
			write_max_entries(phase_limit(ph));
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 99) == 0)
					drain_results();
				d = random_descriptor();
				transmit_descriptor(d, 1'b0, none);
			end
		end

		drain_results();
		if (mismatch_count == 0)
			$display("[memory_map_to_e820_coalescer_unit] OK");
		else
			$display("[memory_map_to_e820_coalescer_unit] ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/e820c_pkg.sv
rtl/e820c_rq.sv
rtl/e820c_core.sv
rtl/memory_map_to_e820_coalescer_unit.sv
tb/tb_memory_map_to_e820_coalescer_unit.sv
